// ===== rtl/slfp_pkg.sv =====
// shared types and constants of the sync/length frame parser
`timescale 1ns / 1ps

package slfp_pkg;

	localparam logic [7:0] SYNC_A = 8'hAA;
	localparam logic [7:0] SYNC_B = 8'h55;
	localparam logic [15:0] HDR_FIELD_BYTES = 16'd3;

	typedef enum logic [3:0] {
		PH_HUNT0    = 4'd0,
		PH_HUNT1    = 4'd1,
		PH_LEN_HI   = 4'd2,
		PH_LEN_LO   = 4'd3,
		PH_TYPE     = 4'd4,
		PH_ID_HI    = 4'd5,
		PH_ID_LO    = 4'd6,
		PH_PAYLOAD  = 4'd7,
		PH_TRL0     = 4'd8,
		PH_TRL1_OK  = 4'd9,
		PH_TRL1_BAD = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD     = 2'd0,
		KIND_GOOD        = 2'd1,
		KIND_BAD_TRAILER = 2'd2,
		KIND_SHORT       = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  payload_byte;
		logic [7:0]  frame_type;
		logic [15:0] frame_id;
		logic [15:0] frame_length;
	} res_t;

	// result handed from the parser to the output stage
	typedef struct packed {
		logic vld;
		res_t res;
	} push_t;

endpackage

// ===== rtl/slfp_byte_if.sv =====
// byte input channel
`timescale 1ns / 1ps

interface slfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/slfp_res_if.sv =====
// result output channel
`timescale 1ns / 1ps

interface slfp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_type;
	logic [15:0] frame_id;
	logic [15:0] frame_length;

	modport source (output valid, output kind, output payload_byte, output frame_type,
		output frame_id, output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_type,
		input frame_id, input frame_length, output ready);
endinterface

// ===== rtl/slfp_parser.sv =====
// frame state machine and header field registers
`timescale 1ns / 1ps

module slfp_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic [7:0]     rx_byte,
	output slfp_pkg::push_t push
);
	import slfp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] length_q, length_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] id_q, id_d;
	logic [15:0] len_full;
	logic [15:0] left_dec;

	assign len_full = {length_q[15:8], rx_byte};
	assign left_dec = left_q - 16'd1;

	// state register and frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT0;
			length_q <= '0;
			left_q   <= '0;
			type_q   <= '0;
			id_q     <= '0;
		end else if (in_fire) begin
			phase_q  <= phase_d;
			length_q <= length_d;
			left_q   <= left_d;
			type_q   <= type_d;
			id_q     <= id_d;
		end
	end

	// next state and result for the byte at the input
	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		left_d   = left_q;
		type_d   = type_q;
		id_d     = id_q;
		push.vld = 1'b0;
		push.res.kind         = KIND_PAYLOAD;
		push.res.payload_byte = '0;
		push.res.frame_type   = type_q;
		push.res.frame_id     = id_q;
		push.res.frame_length = length_q;
		unique case (phase_q)
			PH_HUNT1: begin
				if (rx_byte == SYNC_B) begin
					type_d   = '0;
					id_d     = '0;
					length_d = '0;
					left_d   = '0;
					phase_d  = PH_LEN_HI;
				end else if (rx_byte != SYNC_A) begin
					phase_d = PH_HUNT0;
				end
			end
			PH_LEN_HI: begin
				length_d = {rx_byte, 8'h00};
				phase_d  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_d = len_full;
				if (len_full < HDR_FIELD_BYTES) begin
					phase_d  = PH_HUNT0;
					push.vld = in_fire;
					push.res.kind         = KIND_SHORT;
					push.res.frame_length = len_full;
				end else begin
					left_d  = len_full - HDR_FIELD_BYTES;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				type_d  = rx_byte;
				phase_d = PH_ID_HI;
			end
			PH_ID_HI: begin
				id_d    = {rx_byte, 8'h00};
				phase_d = PH_ID_LO;
			end
			PH_ID_LO: begin
				id_d    = {id_q[15:8], rx_byte};
				phase_d = (left_q != 16'd0) ? PH_PAYLOAD : PH_TRL0;
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_TRL0;
				end
				push.vld = in_fire;
				push.res.kind         = KIND_PAYLOAD;
				push.res.payload_byte = rx_byte;
			end
			PH_TRL0: begin
				phase_d = (rx_byte == SYNC_B) ? PH_TRL1_OK : PH_TRL1_BAD;
			end
			PH_TRL1_OK, PH_TRL1_BAD: begin
				phase_d  = PH_HUNT0;
				push.vld = in_fire;
				push.res.kind = (phase_q == PH_TRL1_OK && rx_byte == SYNC_A) ?
					KIND_GOOD : KIND_BAD_TRAILER;
			end
			default: begin
				// hunting for the first header byte, also unused codes
				phase_d = (rx_byte == SYNC_A) ? PH_HUNT1 : PH_HUNT0;
			end
		endcase
	end

endmodule

// ===== rtl/slfp_out_stage.sv =====
// result register with a skid entry
`timescale 1ns / 1ps

module slfp_out_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  slfp_pkg::push_t push,
	output logic            in_ready,
	slfp_res_if.source      res
);
	import slfp_pkg::*;

	logic out_vld_q;
	res_t out_q;
	logic skid_vld_q;
	res_t skid_q;
	logic out_fire;
	logic out_free;

	assign out_fire = out_vld_q & res.ready;
	assign out_free = ~out_vld_q | out_fire;
	// bytes keep flowing while the skid entry is empty
	assign in_ready = ~skid_vld_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q  <= skid_vld_q | push.vld;
			skid_vld_q <= 1'b0;
		end else if (push.vld) begin
			skid_vld_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : push.res;
		end else if (push.vld) begin
			skid_q <= push.res;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.kind         = out_q.kind;
	assign res.payload_byte = out_q.payload_byte;
	assign res.frame_type   = out_q.frame_type;
	assign res.frame_id     = out_q.frame_id;
	assign res.frame_length = out_q.frame_length;

endmodule

// ===== rtl/sync_length_frame_parser_top.sv =====
// top level of the sync/length frame parser
// Deframer for a byte stream. Bytes arrive on the rx channel (valid/ready,
// one rx_byte per transfer). The block hunts for the header AA 55, reads a
// big-endian length, a type byte, a 16-bit id, length-3 payload bytes and
// a 55 AA trailer. Each payload byte leaves on the res channel as kind 0;
// at the trailer a status of kind 1 (good) or 2 (bad trailer) follows, and
// a length below three gives kind 3 right after the low length byte.
// Every result carries the current type, id and length fields.
// Throughput: one byte per cycle while rx ready is high; each result is formed
// combinationally from the frame state and the rx byte and is registered
// into the result register, or into the skid entry while res stalls.
// When res stalls, a skid entry takes one more result; rx ready drops only
// while that entry is occupied.
// Reset (arst_n low) returns the block to hunting, clears the fields and
// drops all pending results.
`timescale 1ns / 1ps

module sync_length_frame_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	slfp_byte_if.sink   rx,
	slfp_res_if.source  res
);
	import slfp_pkg::*;

	logic  in_fire;
	logic  in_ready;
	push_t push;

	assign rx.ready = in_ready;
	assign in_fire  = rx.valid & in_ready;

	// frame parsing
	slfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.rx_byte (rx.rx_byte),
		.push    (push)
	);

	// result register
	slfp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_ready (in_ready),
		.res      (res)
	);

endmodule
